// ===== rtl/cpv_pkg.sv =====
// Shared constants, types and elaboration-time table helpers for the velocity control unit.
package cpv_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SIGMOID_TABLE_DEPTH = 256;
	localparam logic signed [31:0] FLOOR_HEIGHT_Q = 32'sd1966;
	localparam int XMAX_LOG2 = 4;
	localparam int DIST_LAT = 36;

	localparam logic [1:0] MODE_FIXED = 2'd0;
	localparam logic [1:0] MODE_DIST = 2'd1;
	localparam logic [1:0] MODE_SIGMOID = 2'd2;

	localparam logic [31:0] RST_DIST_GAIN = 32'd655360;
	localparam logic [63:0] RST_SIG_PAIR = 64'h0001_0000_0001_0000;
	localparam logic [31:0] RST_GAIN_OFFSET = 32'd65536;

	typedef enum logic [2:0] {
		REG_GAIN_MODE = 3'd0,
		REG_FIXED_GAINS = 3'd1,
		REG_DIST_GAIN = 3'd2,
		REG_SIG_GAINS = 3'd3,
		REG_SIG_SLOPES = 3'd4,
		REG_SIG_KNEES = 3'd5,
		REG_GAIN_OFFSET = 3'd6
	} reg_index_t;

	typedef logic signed [33:0] gain_t;

	typedef struct packed {
		logic [31:0] ga;
		logic [31:0] gb;
		logic [31:0] sa;
		logic [31:0] sb;
		logic [31:0] kn;
		logic [31:0] kf;
		logic [31:0] c;
	} sig_cfg_t;

	typedef struct packed {
		gain_t gain;
		logic sat;
	} dist_gain_t;

	typedef struct packed {
		logic esat;
		logic gsat;
		logic vsat;
	} lane_flags_t;

	// Long division by shift and subtract, used only while the design elaborates.
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], a[i]};
			if (r >= {1'b0, b}) begin
				r = r - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Taylor series of exp(-16 / depth) in Q0.32.
	function automatic logic [63:0] exp_ratio(input int depth);
		logic [63:0] r;
		logic [63:0] t;
		logic stop;
		r = 64'h1_0000_0000;
		t = 64'h1_0000_0000;
		stop = 1'b0;
		for (int n = 1; n < 64; n++) begin
			if (!stop) begin
				t = udiv64(t << XMAX_LOG2, 64'(depth) * 64'(n));
				if (t == 64'd0) begin
					stop = 1'b1;
				end else if (n[0]) begin
					r = r - t;
				end else begin
					r = r + t;
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/cpv_delay.sv =====
// Fixed-length register delay line.
module cpv_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input logic clk,
	input logic arst_n,
	input logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				pipe_q[i] <= '0;
			end
		end else begin
			pipe_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				pipe_q[i] <= pipe_q[i-1];
			end
		end
	end

	assign q = pipe_q[N-1];

endmodule

// ===== rtl/cpv_udiv.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module cpv_udiv #(
	parameter int NUM_W = 50,
	parameter int DEN_W = 34,
	parameter int Q_W = 17
) (
	input logic clk,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	output logic [Q_W-1:0] quo
);

	logic [NUM_W-1:0] rem_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0] quo_s [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_stage
		localparam int K = Q_W - 1 - j;
		logic [NUM_W-1:0] rin;
		logic [DEN_W-1:0] din;
		logic [Q_W-1:0] qin;
		logic [NUM_W-1:0] trial;

		if (j == 0) begin : g_first
			assign rin = num;
			assign din = den;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[j-1];
			assign din = den_s[j-1];
			assign qin = quo_s[j-1];
		end

		assign trial = NUM_W'(din) << K;

		always_ff @(posedge clk) begin
			den_s[j] <= din;
			if (rin >= trial) begin
				rem_s[j] <= rin - trial;
				quo_s[j] <= qin | (Q_W'(1) << K);
			end else begin
				rem_s[j] <= rin;
				quo_s[j] <= qin;
			end
		end
	end

	assign quo = quo_s[Q_W-1];

endmodule

// ===== rtl/cpv_dist.sv =====
// Distance-scaled gain: squared error norm, pipelined integer square root, gain scaling.
module cpv_dist #(
	parameter int FRAC_BITS = cpv_pkg::FRAC_BITS
) (
	input logic clk,
	input logic [2:0][31:0] err,
	input logic [31:0] dist_gain,
	output cpv_pkg::dist_gain_t gain_out
);

	logic [63:0] sq_s1 [3];
	logic [63:0] rem_s [33];
	logic [63:0] root_s [33];
	logic [63:0] prod_s35;
	cpv_pkg::dist_gain_t gain_s36;
	logic [63:0] scaled;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sq_s1[k] <= 64'($signed(err[k])) * 64'($signed(err[k]));
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		root_s[0] <= '0;
	end

	for (genvar k = 0; k < 32; k++) begin : g_root
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;

		assign trial = root_s[k] + BIT;

		always_ff @(posedge clk) begin
			if (rem_s[k] >= trial) begin
				rem_s[k+1] <= rem_s[k] - trial;
				root_s[k+1] <= (root_s[k] >> 1) + BIT;
			end else begin
				rem_s[k+1] <= rem_s[k];
				root_s[k+1] <= root_s[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s35 <= 64'(dist_gain) * 64'(root_s[32][31:0]);
	end

	assign scaled = prod_s35 >> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (scaled > 64'h1_0000_0000) begin
			gain_s36.gain <= 34'sh1_0000_0000;
			gain_s36.sat <= 1'b1;
		end else begin
			gain_s36.gain <= 34'(scaled);
			gain_s36.sat <= 1'b0;
		end
	end

	assign gain_out = gain_s36;

endmodule

// ===== rtl/cpv_lane.sv =====
// One axis lane: sigmoid gain, gain selection and saturating velocity.
module cpv_lane #(
	parameter int FRAC_BITS = cpv_pkg::FRAC_BITS,
	parameter int SIGMOID_TABLE_DEPTH = cpv_pkg::SIGMOID_TABLE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic [31:0] err,
	input logic esat,
	input logic [1:0] gain_mode,
	input logic [15:0] fixed_gain,
	input cpv_pkg::sig_cfg_t sig_cfg,
	input cpv_pkg::dist_gain_t dist_gain,
	output logic [31:0] err_out,
	output logic [31:0] vel,
	output cpv_pkg::lane_flags_t flags
);

	localparam int IDX_W = $clog2(SIGMOID_TABLE_DEPTH);
	localparam int DW = $clog2(SIGMOID_TABLE_DEPTH + 1);
	localparam int PW = FRAC_BITS + 4 + DW;
	localparam int NUM_W = 34 + FRAC_BITS;
	localparam int Q_W = FRAC_BITS + 1;
	localparam int SIG_PAD = cpv_pkg::DIST_LAT - (FRAC_BITS + 7);
	localparam logic signed [34:0] GMAX = 35'sh1_0000_0000;
	localparam logic signed [34:0] GMIN = -35'sh1_0000_0000;

	typedef logic [32:0] tab_t [SIGMOID_TABLE_DEPTH];

	function automatic tab_t build_tab();
		tab_t tb;
		logic [63:0] r;
		logic [97:0] p;
		r = cpv_pkg::exp_ratio(SIGMOID_TABLE_DEPTH);
		tb[0] = 33'h1_0000_0000;
		for (int i = 1; i < SIGMOID_TABLE_DEPTH; i++) begin
			p = 98'(tb[i-1]) * 98'(r) + 98'h8000_0000;
			tb[i] = p[64:32];
		end
		return tb;
	endfunction

	localparam tab_t EXP_TAB = build_tab();

	logic [31:0] emag;
	logic [33:0] diff [2];
	logic [31:0] slope [2];
	logic [31:0] gsig [2];
	logic [63:0] prod [2];
	logic [PW-1:0] scaled [2];
	logic [NUM_W-1:0] num [2];
	logic [33:0] den [2];
	logic [Q_W-1:0] quo [2];
	logic [63:0] tprod [2];

	logic [31:0] ad_s1 [2];
	logic pos_s1 [2];
	logic [FRAC_BITS+3:0] mag_s2 [2];
	logic lt_s2 [2];
	logic pos_s2 [2];
	logic [IDX_W-1:0] idx_s3 [2];
	logic lt_s3 [2];
	logic pos_s3 [2];
	logic [32:0] e_s4 [2];
	logic pos_s4 [2];
	logic [31:0] term_s5 [2];
	logic signed [34:0] gsum;
	cpv_pkg::gain_t sg_s6;
	logic ssat_s6;

	cpv_pkg::gain_t sg_d;
	logic ssat_d;
	logic [31:0] err_d;
	logic esat_d;

	cpv_pkg::gain_t gsel;
	logic gsat_c;
	logic [32:0] gmag_s7;
	logic gneg_s7;
	logic [31:0] emag_s7;
	logic eneg_s7;
	logic [31:0] err_s7;
	logic esat_s7;
	logic gsat_s7;
	logic [64:0] prod_s8;
	logic neg_s8;
	logic [31:0] err_s8;
	logic esat_s8;
	logic gsat_s8;
	logic [64:0] pv;
	logic [31:0] vel_s9;
	logic vsat_s9;
	logic [31:0] err_s9;
	logic esat_s9;
	logic gsat_s9;

	always_comb begin
		emag = err[31] ? (~err + 32'd1) : err;
		diff[0] = {2'b00, emag} - {2'b00, sig_cfg.kn};
		diff[1] = {2'b00, sig_cfg.kf} - {2'b00, emag};
		slope[0] = sig_cfg.sa;
		slope[1] = sig_cfg.sb;
		gsig[0] = sig_cfg.ga;
		gsig[1] = sig_cfg.gb;
		for (int k = 0; k < 2; k++) begin
			prod[k] = 64'(ad_s1[k]) * 64'(slope[k]);
			scaled[k] = PW'(mag_s2[k]) * PW'(SIGMOID_TABLE_DEPTH);
			num[k] = pos_s4[k] ? (NUM_W'(e_s4[k]) << FRAC_BITS) : (NUM_W'(1) << (32 + FRAC_BITS));
			den[k] = 34'(e_s4[k]) + (34'd1 << 32);
			tprod[k] = 64'(gsig[k]) * 64'(quo[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 2; k++) begin
			pos_s1[k] <= !diff[k][33];
			ad_s1[k] <= diff[k][33] ? 32'(-diff[k]) : diff[k][31:0];
			lt_s2[k] <= (prod[k] >> (2 * FRAC_BITS + 4)) == 64'd0;
			mag_s2[k] <= prod[k][2*FRAC_BITS+3:FRAC_BITS];
			pos_s2[k] <= pos_s1[k];
			idx_s3[k] <= IDX_W'(scaled[k] >> (FRAC_BITS + 4));
			lt_s3[k] <= lt_s2[k];
			pos_s3[k] <= pos_s2[k];
			e_s4[k] <= lt_s3[k] ? EXP_TAB[idx_s3[k]] : 33'd0;
			pos_s4[k] <= pos_s3[k];
			term_s5[k] <= 32'(tprod[k] >> FRAC_BITS);
		end
	end

	for (genvar k = 0; k < 2; k++) begin : g_div
		cpv_udiv #(
			.NUM_W(NUM_W),
			.DEN_W(34),
			.Q_W(Q_W)
		) u_div (
			.clk(clk),
			.num(num[k]),
			.den(den[k]),
			.quo(quo[k])
		);
	end

	assign gsum = {3'b000, term_s5[0]} + {3'b000, term_s5[1]}
		+ {{3{sig_cfg.c[31]}}, sig_cfg.c};

	always_ff @(posedge clk) begin
		if (gsum > GMAX) begin
			sg_s6 <= 34'(GMAX);
			ssat_s6 <= 1'b1;
		end else if (gsum < GMIN) begin
			sg_s6 <= 34'(GMIN);
			ssat_s6 <= 1'b1;
		end else begin
			sg_s6 <= 34'(gsum);
			ssat_s6 <= 1'b0;
		end
	end

	cpv_delay #(
		.W(35),
		.N(SIG_PAD)
	) u_sig_pad (
		.clk(clk),
		.arst_n(arst_n),
		.d({ssat_s6, sg_s6}),
		.q({ssat_d, sg_d})
	);

	cpv_delay #(
		.W(33),
		.N(cpv_pkg::DIST_LAT)
	) u_err_pad (
		.clk(clk),
		.arst_n(arst_n),
		.d({esat, err}),
		.q({esat_d, err_d})
	);

	always_comb begin
		priority if (gain_mode == cpv_pkg::MODE_DIST) begin
			gsel = dist_gain.gain;
			gsat_c = dist_gain.sat;
		end else if (gain_mode == cpv_pkg::MODE_SIGMOID) begin
			gsel = sg_d;
			gsat_c = ssat_d;
		end else begin
			gsel = 34'(fixed_gain) << (FRAC_BITS - 8);
			gsat_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		gneg_s7 <= gsel[33];
		gmag_s7 <= 33'(gsel[33] ? -gsel : gsel);
		eneg_s7 <= err_d[31];
		emag_s7 <= err_d[31] ? (~err_d + 32'd1) : err_d;
		err_s7 <= err_d;
		esat_s7 <= esat_d;
		gsat_s7 <= gsat_c;

		prod_s8 <= 65'(gmag_s7) * 65'(emag_s7);
		neg_s8 <= gneg_s7 ^ eneg_s7;
		err_s8 <= err_s7;
		esat_s8 <= esat_s7;
		gsat_s8 <= gsat_s7;
	end

	assign pv = prod_s8 >> FRAC_BITS;

	always_ff @(posedge clk) begin
		err_s9 <= err_s8;
		esat_s9 <= esat_s8;
		gsat_s9 <= gsat_s8;
		if (neg_s8) begin
			if (pv > 65'h8000_0000) begin
				vel_s9 <= 32'h8000_0000;
				vsat_s9 <= 1'b1;
			end else begin
				vel_s9 <= 32'(-pv);
				vsat_s9 <= 1'b0;
			end
		end else begin
			if (pv > 65'h7FFF_FFFF) begin
				vel_s9 <= 32'h7FFF_FFFF;
				vsat_s9 <= 1'b1;
			end else begin
				vel_s9 <= pv[31:0];
				vsat_s9 <= 1'b0;
			end
		end
	end

	assign err_out = err_s9;
	assign vel = vel_s9;
	assign flags = '{esat: esat_s9, gsat: gsat_s9, vsat: vsat_s9};

endmodule

// ===== rtl/cartesian_p_velocity_control_unit.sv =====
// Top level of the proportional Cartesian velocity controller with gain scheduling.
// The delay from an accepted beat to its result strobe is the same in every gain mode.
// Throughput is one beat per cycle; the 32-stage square root pipeline of the distance
// path sets the depth, and the sigmoid path is padded to match it.
// The receiver cannot stall, so busy is always low and results appear on done.
// Reset clears the pipeline valid bits and loads every configuration register with its default.
module cartesian_p_velocity_control_unit #(
	parameter int FRAC_BITS = cpv_pkg::FRAC_BITS,
	parameter int SIGMOID_TABLE_DEPTH = cpv_pkg::SIGMOID_TABLE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic motion_active,
	input logic signed [31:0] current_x,
	input logic signed [31:0] current_y,
	input logic signed [31:0] current_z,
	input logic signed [31:0] target_x,
	input logic signed [31:0] target_y,
	input logic signed [31:0] target_z,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data,
	output logic done,
	output logic signed [31:0] error_x,
	output logic signed [31:0] error_y,
	output logic signed [31:0] error_z,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] vel_z,
	output logic halted,
	output logic saturated
);

	localparam int TAIL = cpv_pkg::DIST_LAT + 3;

	logic [1:0] gain_mode_q;
	logic [47:0] fixed_gains_q;
	logic [31:0] dist_gain_q;
	logic [63:0] sig_gains_q;
	logic [63:0] sig_slopes_q;
	logic [63:0] sig_knees_q;
	logic [31:0] gain_offset_q;
	cpv_pkg::sig_cfg_t sig_cfg;

	logic [2:0][31:0] cur;
	logic [2:0][31:0] tgt;
	logic [32:0] dfull [3];
	logic [2:0][31:0] err_c;
	logic [2:0] esat_c;

	logic valid_s1;
	logic [2:0][31:0] err_s1;
	logic [2:0] esat_s1;
	logic halted_s1;

	cpv_pkg::dist_gain_t dist_gain;
	logic [31:0] lane_err [3];
	logic [31:0] lane_vel [3];
	cpv_pkg::lane_flags_t lane_flags [3];
	logic valid_d;
	logic halted_d;

	logic done_q;
	logic [31:0] err_q [3];
	logic [31:0] vel_q [3];
	logic halted_q;
	logic sat_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_mode_q <= cpv_pkg::MODE_FIXED;
			fixed_gains_q <= '0;
			dist_gain_q <= cpv_pkg::RST_DIST_GAIN;
			sig_gains_q <= cpv_pkg::RST_SIG_PAIR;
			sig_slopes_q <= cpv_pkg::RST_SIG_PAIR;
			sig_knees_q <= cpv_pkg::RST_SIG_PAIR;
			gain_offset_q <= cpv_pkg::RST_GAIN_OFFSET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpv_pkg::REG_GAIN_MODE: gain_mode_q <= cfg_data[1:0];
				cpv_pkg::REG_FIXED_GAINS: fixed_gains_q <= cfg_data[47:0];
				cpv_pkg::REG_DIST_GAIN: dist_gain_q <= cfg_data[31:0];
				cpv_pkg::REG_SIG_GAINS: sig_gains_q <= cfg_data;
				cpv_pkg::REG_SIG_SLOPES: sig_slopes_q <= cfg_data;
				cpv_pkg::REG_SIG_KNEES: sig_knees_q <= cfg_data;
				cpv_pkg::REG_GAIN_OFFSET: gain_offset_q <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	assign sig_cfg = '{
		ga: sig_gains_q[31:0],
		gb: sig_gains_q[63:32],
		sa: sig_slopes_q[31:0],
		sb: sig_slopes_q[63:32],
		kn: sig_knees_q[31:0],
		kf: sig_knees_q[63:32],
		c: gain_offset_q
	};

	assign cur = {current_z, current_y, current_x};
	assign tgt = {target_z, target_y, target_x};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dfull[k] = {tgt[k][31], tgt[k]} - {cur[k][31], cur[k]};
			esat_c[k] = dfull[k][32] ^ dfull[k][31];
			if (esat_c[k]) begin
				err_c[k] = dfull[k][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				err_c[k] = dfull[k][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy && motion_active;
		end
	end

	always_ff @(posedge clk) begin
		err_s1 <= err_c;
		esat_s1 <= esat_c;
		halted_s1 <= current_z <= cpv_pkg::FLOOR_HEIGHT_Q;
	end

	cpv_dist #(
		.FRAC_BITS(FRAC_BITS)
	) u_dist (
		.clk(clk),
		.err(err_s1),
		.dist_gain(dist_gain_q),
		.gain_out(dist_gain)
	);

	for (genvar k = 0; k < 3; k++) begin : g_lane
		cpv_lane #(
			.FRAC_BITS(FRAC_BITS),
			.SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.err(err_s1[k]),
			.esat(esat_s1[k]),
			.gain_mode(gain_mode_q),
			.fixed_gain(fixed_gains_q[16*k +: 16]),
			.sig_cfg(sig_cfg),
			.dist_gain(dist_gain),
			.err_out(lane_err[k]),
			.vel(lane_vel[k]),
			.flags(lane_flags[k])
		);
	end

	cpv_delay #(
		.W(2),
		.N(TAIL)
	) u_ctrl_pad (
		.clk(clk),
		.arst_n(arst_n),
		.d({valid_s1, halted_s1}),
		.q({valid_d, halted_d})
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_d;
		end
	end

	// A halted beat drops any velocity clip, but error and gain clips still count.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			err_q[k] <= lane_err[k];
			vel_q[k] <= halted_d ? 32'd0 : lane_vel[k];
		end
		halted_q <= halted_d;
		sat_q <= lane_flags[0].esat | lane_flags[1].esat | lane_flags[2].esat
			| lane_flags[0].gsat | lane_flags[1].gsat | lane_flags[2].gsat
			| (!halted_d & (lane_flags[0].vsat | lane_flags[1].vsat | lane_flags[2].vsat));
	end

	assign done = done_q;
	assign error_x = err_q[0];
	assign error_y = err_q[1];
	assign error_z = err_q[2];
	assign vel_x = vel_q[0];
	assign vel_y = vel_q[1];
	assign vel_z = vel_q[2];
	assign halted = halted_q;
	assign saturated = sat_q;

endmodule
